/* rtl/dltb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltb_pkg: shared types and constants of the delta-list timer bank
// Request/response payloads, sequencer steps, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dltb_pkg;

   localparam int TIMERS  = 16;
   localparam int IDX_W   = $clog2(TIMERS);
   localparam int PTR_W   = IDX_W + 1;
   localparam int SLOT_W  = 4;
   localparam int TICKS_W = 32;

   localparam logic [PTR_W-1:0]   END_PTR   = PTR_W'(TIMERS);
   localparam logic [TICKS_W-1:0] MIN_TICKS = TICKS_W'(2);

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_CANCEL = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_EXPIRED   = 3'd0,
      KIND_STARTED   = 3'd1,
      KIND_REFUSED   = 3'd2,
      KIND_CANCELLED = 3'd3,
      KIND_QUERY     = 3'd4
   } kind_type;

   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   slot;
      logic [TICKS_W-1:0]  ticks;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   slot_out;
      logic [TICKS_W-1:0]  remaining;
      logic                running;
      logic                last;
   } rsp_type;

   typedef enum logic [3:0] {
      STEP_NOP,
      STEP_LOAD,
      STEP_INS_WALK,
      STEP_INS_LINK,
      STEP_INS_SET,
      STEP_CAN_READ,
      STEP_CAN_ADD,
      STEP_CAN_WALK,
      STEP_CAN_UNLINK,
      STEP_QRY_WALK,
      STEP_TICK_DEC,
      STEP_POP,
      STEP_EMIT_LAST,
      STEP_EMIT
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_WALK,
      ST_INS_SET,
      ST_CAN_READ,
      ST_CAN_ADD,
      ST_CAN_WALK,
      ST_QRY_WALK,
      ST_TICK_DEC,
      ST_POP,
      ST_RESP
   } state_type;

   typedef struct packed {
      step_type step;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   slot_armed;
      logic   head_end;
      logic   cur_end;
      logic   cur_is_slot;
      logic   delta_lt;
      logic   delta_zero;
      logic   pend_valid;
      logic   out_free;
   } sts_type;

endpackage

/* rtl/dltb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltb_ctrl: sequencer of the delta-list timer bank
// Decodes each request and steps the datapath through list walks, links,
// expiry pops and response emission.
// ----------------------------------------------------------------------------
module dltb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dltb_pkg::sts_type sts,
   output dltb_pkg::cmd_type cmd
);

   dltb_pkg::state_type state_ff, state_in;
   dltb_pkg::kind_type  kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dltb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         dltb_pkg::ST_IDLE: begin
            if (req_valid) state_in = dltb_pkg::ST_DECODE;
         end
         dltb_pkg::ST_DECODE: begin
            unique case (sts.op)
               dltb_pkg::OP_TICK: begin
                  state_in = sts.head_end ? dltb_pkg::ST_IDLE : dltb_pkg::ST_TICK_DEC;
               end
               dltb_pkg::OP_START: begin
                  if (sts.slot_armed) begin
                     kind_in  = dltb_pkg::KIND_REFUSED;
                     state_in = dltb_pkg::ST_RESP;
                  end else begin
                     kind_in  = dltb_pkg::KIND_STARTED;
                     state_in = dltb_pkg::ST_INS_WALK;
                  end
               end
               dltb_pkg::OP_CANCEL: begin
                  kind_in  = dltb_pkg::KIND_CANCELLED;
                  state_in = sts.slot_armed ? dltb_pkg::ST_CAN_READ : dltb_pkg::ST_RESP;
               end
               dltb_pkg::OP_QUERY: begin
                  kind_in  = dltb_pkg::KIND_QUERY;
                  state_in = sts.slot_armed ? dltb_pkg::ST_QRY_WALK : dltb_pkg::ST_RESP;
               end
               default: state_in = dltb_pkg::ST_IDLE;
            endcase
         end
         dltb_pkg::ST_INS_WALK: begin
            if (sts.cur_end || !sts.delta_lt) state_in = dltb_pkg::ST_INS_SET;
         end
         dltb_pkg::ST_INS_SET: state_in = dltb_pkg::ST_RESP;
         dltb_pkg::ST_CAN_READ: state_in = dltb_pkg::ST_CAN_ADD;
         dltb_pkg::ST_CAN_ADD: state_in = dltb_pkg::ST_CAN_WALK;
         dltb_pkg::ST_CAN_WALK: begin
            if (sts.cur_is_slot) state_in = dltb_pkg::ST_RESP;
         end
         dltb_pkg::ST_QRY_WALK: begin
            if (sts.cur_is_slot) state_in = dltb_pkg::ST_RESP;
         end
         dltb_pkg::ST_TICK_DEC: state_in = dltb_pkg::ST_POP;
         dltb_pkg::ST_POP: begin
            if (!(!sts.cur_end && sts.delta_zero) && (!sts.pend_valid || sts.out_free))
               state_in = dltb_pkg::ST_IDLE;
         end
         dltb_pkg::ST_RESP: begin
            if (sts.out_free) state_in = dltb_pkg::ST_IDLE;
         end
         default: state_in = dltb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.step  = dltb_pkg::STEP_NOP;
      cmd.kind  = kind_ff;
      req_stall = reset || (state_ff != dltb_pkg::ST_IDLE);
      unique case (state_ff)
         dltb_pkg::ST_IDLE: begin
            if (req_valid) cmd.step = dltb_pkg::STEP_LOAD;
         end
         dltb_pkg::ST_DECODE: cmd.step = dltb_pkg::STEP_NOP;
         dltb_pkg::ST_INS_WALK: begin
            cmd.step = (!sts.cur_end && sts.delta_lt) ? dltb_pkg::STEP_INS_WALK
                                                       : dltb_pkg::STEP_INS_LINK;
         end
         dltb_pkg::ST_INS_SET: cmd.step = dltb_pkg::STEP_INS_SET;
         dltb_pkg::ST_CAN_READ: cmd.step = dltb_pkg::STEP_CAN_READ;
         dltb_pkg::ST_CAN_ADD: cmd.step = dltb_pkg::STEP_CAN_ADD;
         dltb_pkg::ST_CAN_WALK: begin
            cmd.step = sts.cur_is_slot ? dltb_pkg::STEP_CAN_UNLINK : dltb_pkg::STEP_CAN_WALK;
         end
         dltb_pkg::ST_QRY_WALK: cmd.step = dltb_pkg::STEP_QRY_WALK;
         dltb_pkg::ST_TICK_DEC: cmd.step = dltb_pkg::STEP_TICK_DEC;
         dltb_pkg::ST_POP: begin
            if (!sts.cur_end && sts.delta_zero) begin
               if (!sts.pend_valid || sts.out_free) cmd.step = dltb_pkg::STEP_POP;
            end else if (sts.pend_valid && sts.out_free) begin
               cmd.step = dltb_pkg::STEP_EMIT_LAST;
            end
         end
         dltb_pkg::ST_RESP: begin
            if (sts.out_free) cmd.step = dltb_pkg::STEP_EMIT;
         end
         default: cmd.step = dltb_pkg::STEP_NOP;
      endcase
   end

endmodule

/* rtl/dltb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltb_datapath: slot storage and list walker of the delta-list timer bank
// Holds per-slot deltas, links and armed flags, the list head, the walk
// pointers and accumulator, a pending expiry and the response register.
// ----------------------------------------------------------------------------
module dltb_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dltb_pkg::req_type req_data,
   input  dltb_pkg::cmd_type cmd,
   output dltb_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dltb_pkg::rsp_type rsp_data
);

   logic [dltb_pkg::TICKS_W-1:0] delta_ff [dltb_pkg::TIMERS];
   dltb_pkg::ptr_type            next_ff  [dltb_pkg::TIMERS];
   logic [dltb_pkg::TIMERS-1:0]  armed_ff;

   dltb_pkg::ptr_type            head_ff, head_in;
   dltb_pkg::ptr_type            cur_ff, cur_in;
   dltb_pkg::ptr_type            prev_ff, prev_in;
   dltb_pkg::ptr_type            nsave_ff, nsave_in;
   logic [dltb_pkg::TICKS_W-1:0] acc_ff, acc_in;
   dltb_pkg::op_type             op_ff, op_in;
   logic [dltb_pkg::SLOT_W-1:0]  slot_ff, slot_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [dltb_pkg::SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   dltb_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         delta_we;
   dltb_pkg::idx_type            delta_wa;
   logic [dltb_pkg::TICKS_W-1:0] delta_wd;
   logic                         next_we;
   dltb_pkg::idx_type            next_wa;
   dltb_pkg::ptr_type            next_wd;
   logic                         armed_we;
   dltb_pkg::idx_type            armed_wa;
   logic                         armed_wd;

   dltb_pkg::idx_type            cur_idx, prev_idx, slot_idx;
   dltb_pkg::ptr_type            slot_ptr, cur_next;
   logic [dltb_pkg::TICKS_W-1:0] cur_delta, start_ticks;
   logic                         slot_ok, slot_armed, cur_end, out_free, emit;
   dltb_pkg::rsp_type            emit_data;

   assign cur_idx     = cur_ff[dltb_pkg::IDX_W-1:0];
   assign prev_idx    = prev_ff[dltb_pkg::IDX_W-1:0];
   assign slot_idx    = dltb_pkg::IDX_W'(slot_ff);
   assign slot_ptr    = dltb_pkg::PTR_W'(slot_ff);
   assign cur_delta   = delta_ff[cur_idx];
   assign cur_next    = next_ff[cur_idx];
   assign cur_end     = (cur_ff == dltb_pkg::END_PTR);
   assign slot_ok     = (32'(slot_ff) < 32'(dltb_pkg::TIMERS));
   assign slot_armed  = slot_ok && armed_ff[slot_idx];
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign start_ticks = (req_data.ticks < dltb_pkg::MIN_TICKS) ? dltb_pkg::MIN_TICKS
                                                               : req_data.ticks;

   always_comb begin
      sts.op          = op_ff;
      sts.slot_armed  = slot_armed;
      sts.head_end    = (head_ff == dltb_pkg::END_PTR);
      sts.cur_end     = cur_end;
      sts.cur_is_slot = !cur_end && (cur_ff == slot_ptr);
      sts.delta_lt    = (cur_delta < acc_ff);
      sts.delta_zero  = (cur_delta == '0);
      sts.pend_valid  = pend_valid_ff;
      sts.out_free    = out_free;
   end

   always_comb begin
      head_in       = head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      nsave_in      = nsave_ff;
      acc_in        = acc_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      delta_we      = 1'b0;
      delta_wa      = cur_idx;
      delta_wd      = cur_delta;
      next_we       = 1'b0;
      next_wa       = prev_idx;
      next_wd       = slot_ptr;
      armed_we      = 1'b0;
      armed_wa      = slot_idx;
      armed_wd      = 1'b0;
      emit          = 1'b0;
      emit_data     = '{kind: dltb_pkg::KIND_EXPIRED, slot_out: pend_slot_ff,
                        remaining: '0, running: 1'b0, last: 1'b0};
      unique case (cmd.step)
         dltb_pkg::STEP_NOP: begin
         end
         dltb_pkg::STEP_LOAD: begin
            op_in         = req_data.op;
            slot_in       = req_data.slot;
            prev_in       = dltb_pkg::END_PTR;
            pend_valid_in = 1'b0;
            cur_in        = (req_data.op == dltb_pkg::OP_CANCEL)
                            ? dltb_pkg::PTR_W'(req_data.slot) : head_ff;
            acc_in        = (req_data.op == dltb_pkg::OP_START) ? start_ticks : '0;
         end
         dltb_pkg::STEP_INS_WALK: begin
            acc_in  = acc_ff - cur_delta;
            prev_in = cur_ff;
            cur_in  = cur_next;
         end
         dltb_pkg::STEP_INS_LINK: begin
            next_we  = 1'b1;
            next_wa  = slot_idx;
            next_wd  = cur_ff;
            delta_we = !cur_end;
            delta_wd = cur_delta - acc_ff;
         end
         dltb_pkg::STEP_INS_SET: begin
            delta_we = 1'b1;
            delta_wa = slot_idx;
            delta_wd = acc_ff;
            armed_we = 1'b1;
            armed_wd = 1'b1;
            if (prev_ff == dltb_pkg::END_PTR) begin
               head_in = slot_ptr;
            end else begin
               next_we = 1'b1;
            end
         end
         dltb_pkg::STEP_CAN_READ: begin
            acc_in   = cur_delta;
            nsave_in = cur_next;
            cur_in   = cur_next;
         end
         dltb_pkg::STEP_CAN_ADD: begin
            delta_we = !cur_end;
            delta_wd = cur_delta + acc_ff;
            cur_in   = head_ff;
            prev_in  = dltb_pkg::END_PTR;
         end
         dltb_pkg::STEP_CAN_WALK: begin
            prev_in = cur_ff;
            cur_in  = cur_next;
         end
         dltb_pkg::STEP_CAN_UNLINK: begin
            armed_we = 1'b1;
            if (prev_ff == dltb_pkg::END_PTR) begin
               head_in = nsave_ff;
            end else begin
               next_we = 1'b1;
               next_wd = nsave_ff;
            end
         end
         dltb_pkg::STEP_QRY_WALK: begin
            acc_in = acc_ff + cur_delta;
            cur_in = cur_next;
         end
         dltb_pkg::STEP_TICK_DEC: begin
            delta_we = (cur_delta != '0);
            delta_wd = cur_delta - dltb_pkg::TICKS_W'(1);
         end
         dltb_pkg::STEP_POP: begin
            head_in       = cur_next;
            cur_in        = cur_next;
            armed_we      = 1'b1;
            armed_wa      = cur_idx;
            pend_valid_in = 1'b1;
            pend_slot_in  = dltb_pkg::SLOT_W'(cur_idx);
            emit          = pend_valid_ff;
         end
         dltb_pkg::STEP_EMIT_LAST: begin
            emit           = 1'b1;
            emit_data.last = 1'b1;
            pend_valid_in  = 1'b0;
         end
         dltb_pkg::STEP_EMIT: begin
            emit      = 1'b1;
            emit_data = '{kind: cmd.kind, slot_out: slot_ff,
                          remaining: (cmd.kind == dltb_pkg::KIND_QUERY) ? acc_ff : '0,
                          running: (cmd.kind == dltb_pkg::KIND_QUERY) && slot_armed,
                          last: 1'b1};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (delta_we) delta_ff[delta_wa] <= delta_wd;
      if (next_we) next_ff[next_wa] <= next_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= '0;
         head_ff       <= dltb_pkg::END_PTR;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (armed_we) armed_ff[armed_wa] <= armed_wd;
         head_ff       <= head_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      nsave_ff     <= nsave_in;
      acc_ff       <= acc_in;
      op_ff        <= op_in;
      slot_ff      <= slot_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/delta_list_timer_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_bank: one-shot timer slots kept in expiry order
// Slots live in one linked list holding per-slot deltas; a tick pops every
// expired slot at the head, most recently started first among equals.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_data (op, slot, ticks)
//   rsp      out  rsp_valid/rsp_stall   rsp_data (kind, slot_out, remaining,
//                                                 running, last)
//
// One request at a time; a list walk visits one slot per cycle. A start walks
// to its place, links and sets the slot; a cancel adds the slot's delta to its
// successor and walks from the head to unlink it; a query sums the deltas up
// to and including its slot. A tick decrements the head delta, then pops.
// A stalled response holds the sequencer only when a new result must be emitted.
// Reset empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
module delta_list_timer_bank (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dltb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dltb_pkg::rsp_type rsp_data
);

   dltb_pkg::cmd_type cmd;
   dltb_pkg::sts_type sts;

   dltb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dltb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/dltb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dltb_checker: port-level checks of the delta-list timer bank
// Handshake hold rules, response field consistency and reset behavior.
// ----------------------------------------------------------------------------
module dltb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input dltb_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dltb_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request dropped or changed while stalled");

   a_remaining_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != dltb_pkg::KIND_QUERY)
         |-> (rsp_data.remaining == '0) && !rsp_data.running)
      else $error("remaining or running set outside a query answer");

   a_command_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != dltb_pkg::KIND_EXPIRED) |-> rsp_data.last)
      else $error("command answer without last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending right after reset");

endmodule

bind delta_list_timer_bank dltb_checker u_dltb_checker (.*);
